### sv/rpn_stack_calculator_core_defines.svh
// ----------------------------------------------------------------------------
// rpn stack calculator assertion macros
// shared concurrent assertion helpers, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_CORE_DEFINES_SVH
`define RPN_STACK_CALCULATOR_CORE_DEFINES_SVH

// plain property check
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RPN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn stack calculator package
// stack sizing, operation and status codes, sequencer states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned DEPTH_W = 11;
  localparam int unsigned CMP_W   = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned STEP_W  = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK_TOP = 3'd2,
    OP_PEEK_BOT = 3'd3,
    OP_ADD      = 3'd4,
    OP_SUB      = 3'd5,
    OP_MUL      = 3'd6,
    OP_DIV      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_FULL  = 3'd1,
    STAT_EMPTY = 3'd2,
    STAT_RANGE = 3'd3,
    STAT_FEW   = 3'd4,
    STAT_DIV0  = 3'd5
  } status_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD1  = 7'b0000010,
    ST_RD2  = 7'b0000100,
    ST_EXEC = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIX  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

endpackage

### sv/rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// rpn stack calculator core
// postfix calculator on a bounded stack of 32-bit signed words
// ----------------------------------------------------------------------------
// Each input word carries one operation (push, pop, peek from top or bottom,
// add, subtract, multiply, divide) and gives exactly one output word with the
// result, a status code and the stack depth after the operation. The stack
// lives in a single-port-read ram, so operands are fetched one per cycle, and
// a small sequencer drives one shared 33-bit add/subtract unit for add,
// subtract, every step of a restoring radix-2 divider and the final sign fix.
// Push and any error other than divide by zero go straight to the result;
// pop and peek read one entry, add/subtract/multiply and divide by zero
// read two and execute, and divide then runs 32 divider steps and a sign
// fix step. The block accepts nothing while a
// word is in progress; it does accept a new word while the previous result
// still waits in the output register, and then stalls only at the end of
// that word until the output is taken. The stack ram needs no clearing after
// reset: only entries below the depth are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rpn_stack_calculator_core_defines.svh"

module rpn_stack_calculator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [31:0] value, [41:32] index, [47:42] zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] operation
  // result word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] result, [42:32] depth, [47:43] zero
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  localparam int unsigned AW      = rpn_pkg::AW;
  localparam int unsigned CW      = rpn_pkg::CW;
  localparam int unsigned WORD_W  = rpn_pkg::WORD_W;
  localparam int unsigned STEP_W  = rpn_pkg::STEP_W;
  localparam int unsigned CMP_W   = rpn_pkg::CMP_W;
  localparam int unsigned DEPTH_W = rpn_pkg::DEPTH_W;

  // sequencer and stack control
  rpn_pkg::state_e      state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  rpn_pkg::op_e         op_q, op_d;
  rpn_pkg::status_e     status_q, status_d;

  // operand and result payload
  logic [WORD_W-1:0]    val_q, val_d;
  logic [WORD_W-1:0]    top_q, top_d;
  logic [WORD_W-1:0]    sec_q, sec_d;
  logic [WORD_W-1:0]    res_q, res_d;

  // divider state: quotient shifts in from the right as dividend shifts out
  logic [WORD_W-1:0]    quo_q, quo_d;
  logic [WORD_W-1:0]    rem_q, rem_d;
  logic [WORD_W-1:0]    dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic [STEP_W-1:0]    step_q, step_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [WORD_W-1:0]    out_res_q, out_res_d;
  rpn_pkg::status_e     out_status_q, out_status_d;
  logic [DEPTH_W-1:0]   out_depth_q, out_depth_d;

  // stack ram ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  // shared add/subtract unit
  logic [WORD_W:0]      alu_a;
  logic [WORD_W:0]      alu_b;
  logic                 alu_sub;
  logic [WORD_W+1:0]    alu_full;
  logic [WORD_W:0]      alu_sum;
  logic                 alu_cout;

  logic [WORD_W-1:0]    mul_lo;
  logic                 in_fire;
  logic                 out_load;
  rpn_pkg::op_e         in_op;
  logic [WORD_W-1:0]    in_value;
  logic [rpn_pkg::IDX_W-1:0] in_index;

  assign in_op    = rpn_pkg::op_e'(s_axis_tuser_i[2:0]);
  assign in_value = s_axis_tdata_i[31:0];
  assign in_index = s_axis_tdata_i[41:32];

  assign s_axis_tready_o = (state_q == rpn_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  // result leaves the sequencer once the output register is free
  assign out_load        = (state_q == rpn_pkg::ST_DONE) & (~out_valid_q | m_axis_tready_i);

  // carry out of a subtract means no borrow
  assign alu_full = {1'b0, alu_a} + {1'b0, alu_b ^ {(WORD_W+1){alu_sub}}}
                  + (WORD_W+2)'(alu_sub);
  assign alu_sum  = alu_full[WORD_W:0];
  assign alu_cout = alu_full[WORD_W+1];

  // low word of the product is the same for signed and unsigned operands
  assign mul_lo = sec_q * top_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    op_d         = op_q;
    status_d     = status_q;
    val_d        = val_q;
    top_d        = top_q;
    sec_d        = sec_q;
    res_d        = res_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    dvs_d        = dvs_q;
    neg_d        = neg_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_res_d    = out_res_q;
    out_status_d = out_status_q;
    out_depth_d  = out_depth_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;

    unique case (state_q)
      rpn_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d     = in_op;
          val_d    = in_value;
          res_d    = '0;
          status_d = rpn_pkg::STAT_OK;
          unique case (in_op)
            rpn_pkg::OP_PUSH: begin
              if (count_q == CW'(rpn_pkg::DEPTH)) begin
                status_d = rpn_pkg::STAT_FULL;
              end
              state_d = rpn_pkg::ST_DONE;
            end
            rpn_pkg::OP_POP: begin
              if (count_q == '0) begin
                status_d = rpn_pkg::STAT_EMPTY;
                state_d  = rpn_pkg::ST_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(count_q - CW'(1));
                state_d   = rpn_pkg::ST_RD1;
              end
            end
            rpn_pkg::OP_PEEK_TOP, rpn_pkg::OP_PEEK_BOT: begin
              if (CMP_W'(in_index) >= CMP_W'(count_q)) begin
                status_d = rpn_pkg::STAT_RANGE;
                state_d  = rpn_pkg::ST_DONE;
              end else begin
                ram_re = 1'b1;
                // index is below the depth here, so it fits the count width
                if (in_op == rpn_pkg::OP_PEEK_TOP) begin
                  ram_raddr = AW'(count_q - CW'(in_index) - CW'(1));
                end else begin
                  ram_raddr = AW'(in_index);
                end
                state_d = rpn_pkg::ST_RD1;
              end
            end
            default: begin
              if (count_q < CW'(2)) begin
                status_d = rpn_pkg::STAT_FEW;
                state_d  = rpn_pkg::ST_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(count_q - CW'(1));
                state_d   = rpn_pkg::ST_RD1;
              end
            end
          endcase
        end
      end
      rpn_pkg::ST_RD1: begin
        if (op_q[2]) begin
          // binary: top arrived, fetch second from top
          top_d     = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = AW'(count_q - CW'(2));
          state_d   = rpn_pkg::ST_RD2;
        end else begin
          res_d   = ram_rdata;
          state_d = rpn_pkg::ST_DONE;
        end
      end
      rpn_pkg::ST_RD2: begin
        sec_d   = ram_rdata;
        state_d = rpn_pkg::ST_EXEC;
      end
      rpn_pkg::ST_EXEC: begin
        unique case (op_q)
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
            alu_a   = {1'b0, sec_q};
            alu_b   = {1'b0, top_q};
            alu_sub = (op_q == rpn_pkg::OP_SUB);
            res_d   = alu_sum[WORD_W-1:0];
            state_d = rpn_pkg::ST_DONE;
          end
          rpn_pkg::OP_MUL: begin
            res_d   = mul_lo;
            state_d = rpn_pkg::ST_DONE;
          end
          rpn_pkg::OP_DIV: begin
            if (top_q == '0) begin
              status_d = rpn_pkg::STAT_DIV0;
              state_d  = rpn_pkg::ST_DONE;
            end else begin
              quo_d   = sec_q[WORD_W-1] ? (WORD_W'(0) - sec_q) : sec_q;
              dvs_d   = top_q[WORD_W-1] ? (WORD_W'(0) - top_q) : top_q;
              rem_d   = '0;
              neg_d   = sec_q[WORD_W-1] ^ top_q[WORD_W-1];
              step_d  = STEP_W'(rpn_pkg::DIV_STEPS - 1);
              state_d = rpn_pkg::ST_DIV;
            end
          end
          default: begin
            state_d = rpn_pkg::ST_DONE;
          end
        endcase
      end
      rpn_pkg::ST_DIV: begin
        // one restoring step: shift in next dividend bit, trial subtract
        alu_a   = {rem_q, quo_q[WORD_W-1]};
        alu_b   = {1'b0, dvs_q};
        alu_sub = 1'b1;
        rem_d   = alu_cout ? alu_sum[WORD_W-1:0] : alu_a[WORD_W-1:0];
        quo_d   = {quo_q[WORD_W-2:0], alu_cout};
        step_d  = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = rpn_pkg::ST_FIX;
        end
      end
      rpn_pkg::ST_FIX: begin
        // negate when the operand signs differ; min / -1 wraps by itself
        alu_a   = '0;
        alu_b   = {1'b0, quo_q};
        alu_sub = neg_q;
        res_d   = alu_sum[WORD_W-1:0];
        state_d = rpn_pkg::ST_DONE;
      end
      rpn_pkg::ST_DONE: begin
        if (out_load) begin
          if (status_q == rpn_pkg::STAT_OK) begin
            unique case (op_q)
              rpn_pkg::OP_PUSH: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = val_q;
                count_d   = count_q + CW'(1);
              end
              rpn_pkg::OP_POP: begin
                count_d = count_q - CW'(1);
              end
              rpn_pkg::OP_PEEK_TOP, rpn_pkg::OP_PEEK_BOT: begin
                count_d = count_q;
              end
              default: begin
                // two operands replaced by the result
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q - CW'(2));
                ram_wdata = res_q;
                count_d   = count_q - CW'(1);
              end
            endcase
          end else if (status_q == rpn_pkg::STAT_DIV0) begin
            // both operands are dropped from the stack
            count_d = count_q - CW'(2);
          end
          out_valid_d  = 1'b1;
          out_res_d    = res_q;
          out_status_d = status_q;
          out_depth_d  = DEPTH_W'(count_d);
          state_d      = rpn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rpn_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpn_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    status_q     <= status_d;
    val_q        <= val_d;
    top_q        <= top_d;
    sec_q        <= sec_d;
    res_q        <= res_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    dvs_q        <= dvs_d;
    neg_q        <= neg_d;
    step_q       <= step_d;
    out_res_q    <= out_res_d;
    out_status_q <= out_status_d;
    out_depth_q  <= out_depth_d;
  end

  rpn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (rpn_pkg::DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_depth_q, out_res_q};
  assign m_axis_tuser_o  = out_status_q;

  // assertions
  `RPN_ASSERT(a_count_bound, count_q <= CW'(rpn_pkg::DEPTH), "stack count beyond depth")
  `RPN_ASSERT_IMP(a_we_only_done, ram_we, out_load, "stack written outside result load")
  `RPN_ASSERT_NXT(a_count_stable, !out_load, $stable(count_q), "count moved without a result")
  `RPN_ASSERT_NXT(a_div_end, (state_q == rpn_pkg::ST_DIV) && (step_q == '0),
                  state_q == rpn_pkg::ST_FIX, "divider did not finish after last step")
  `RPN_ASSERT_IMP(a_rem_bound, state_q == rpn_pkg::ST_DIV, rem_q < dvs_q,
                  "partial remainder not below divisor")

endmodule

### sv/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
